@@ hdl/sukl_pkg.sv @@
// ----------------------------------------------------------------------------
// sukl_pkg
// Shared types for the sorted unique key list: opcodes, result status codes,
// address selects, and the command/status bundles between FSM and datapath.
// ----------------------------------------------------------------------------
package sukl_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_LIST   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_DUP      = 3'd1,
    STAT_NOTFOUND = 3'd2,
    STAT_EMPTY    = 3'd3,
    STAT_FULL     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    RA_ZERO,
    RA_NEXT,
    RA_PREV,
    RA_CNTM1,
    RA_POSP1
  } rsel_e;

  typedef enum logic [1:0] {
    WA_UP,
    WA_DOWN,
    WA_POS
  } wsel_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_DECIDE,
    S_SHU,
    S_WKEY,
    S_SHD,
    S_LIST
  } state_e;

  typedef struct packed {
    logic    load_in;
    logic    rd_en;
    rsel_e   rd_sel;
    logic    wr_en;
    wsel_e   wr_sel;
    logic    scan_hit;
    logic    scan_end;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    emit;
    status_e emit_status;
    logic    emit_rd;
    logic    emit_last;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic cnt_zero;
    logic cnt_full;
    logic ge;
    logic ra_last;
    logic ra_at_pos;
    logic pos_last;
    logic pos_at_cnt;
    logic found;
    logic out_free;
  } sts_t;

endpackage

@@ hdl/sukl_ram.sv @@
// ----------------------------------------------------------------------------
// sukl_ram
// Generic single-write, single-read RAM with registered read data.
// Read data holds while the read enable is low.
// ----------------------------------------------------------------------------
module sukl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/sukl_ctrl.sv @@
// ----------------------------------------------------------------------------
// sukl_ctrl
// Sequencer for the key list: scan for position, shift up or down through
// the RAM one entry per cycle, stream out the list, and issue results.
// ----------------------------------------------------------------------------
module sukl_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sukl_pkg::sts_t sts_i,
  output sukl_pkg::cmd_t cmd_o
);

  sukl_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sukl_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.emit_status = sukl_pkg::STAT_OK;
    cmd_o.rd_sel      = sukl_pkg::RA_ZERO;
    cmd_o.wr_sel      = sukl_pkg::WA_UP;

    unique case (state_q)
      sukl_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = sukl_pkg::S_START;
        end
      end

      sukl_pkg::S_START: begin
        priority if (sts_i.op != sukl_pkg::OP_INSERT && sts_i.cnt_zero) begin
          if (sts_i.out_free) begin
            cmd_o.emit        = 1'b1;
            cmd_o.emit_status = sukl_pkg::STAT_EMPTY;
            cmd_o.emit_last   = 1'b1;
            state_d           = sukl_pkg::S_IDLE;
          end
        end else if (sts_i.op == sukl_pkg::OP_LIST) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = sukl_pkg::RA_ZERO;
          state_d      = sukl_pkg::S_LIST;
        end else if (sts_i.cnt_zero) begin
          cmd_o.scan_end = 1'b1;
          state_d        = sukl_pkg::S_WKEY;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = sukl_pkg::RA_ZERO;
          state_d      = sukl_pkg::S_SCAN;
        end
      end

      sukl_pkg::S_SCAN: begin
        priority if (sts_i.ge) begin
          cmd_o.scan_hit = 1'b1;
          state_d        = sukl_pkg::S_DECIDE;
        end else if (sts_i.ra_last) begin
          cmd_o.scan_end = 1'b1;
          state_d        = sukl_pkg::S_DECIDE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = sukl_pkg::RA_NEXT;
        end
      end

      sukl_pkg::S_DECIDE: begin
        unique case (sts_i.op)
          sukl_pkg::OP_INSERT: begin
            priority if (sts_i.found || sts_i.cnt_full) begin
              if (sts_i.out_free) begin
                cmd_o.emit        = 1'b1;
                cmd_o.emit_status = sts_i.found ? sukl_pkg::STAT_DUP : sukl_pkg::STAT_FULL;
                cmd_o.emit_last   = 1'b1;
                state_d           = sukl_pkg::S_IDLE;
              end
            end else if (sts_i.pos_at_cnt) begin
              state_d = sukl_pkg::S_WKEY;
            end else begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = sukl_pkg::RA_CNTM1;
              state_d      = sukl_pkg::S_SHU;
            end
          end
          sukl_pkg::OP_DELETE: begin
            priority if (!sts_i.found || sts_i.pos_last) begin
              if (sts_i.out_free) begin
                cmd_o.emit        = 1'b1;
                cmd_o.emit_status = sts_i.found ? sukl_pkg::STAT_OK : sukl_pkg::STAT_NOTFOUND;
                cmd_o.emit_last   = 1'b1;
                cmd_o.cnt_dec     = sts_i.found;
                state_d           = sukl_pkg::S_IDLE;
              end
            end else begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = sukl_pkg::RA_POSP1;
              state_d      = sukl_pkg::S_SHD;
            end
          end
          sukl_pkg::OP_SEARCH: begin
            if (sts_i.out_free) begin
              cmd_o.emit        = 1'b1;
              cmd_o.emit_status = sts_i.found ? sukl_pkg::STAT_OK : sukl_pkg::STAT_NOTFOUND;
              cmd_o.emit_last   = 1'b1;
              state_d           = sukl_pkg::S_IDLE;
            end
          end
          sukl_pkg::OP_LIST: begin
            state_d = sukl_pkg::S_IDLE;
          end
        endcase
      end

      sukl_pkg::S_SHU: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = sukl_pkg::WA_UP;
        if (sts_i.ra_at_pos) begin
          state_d = sukl_pkg::S_WKEY;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = sukl_pkg::RA_PREV;
        end
      end

      sukl_pkg::S_WKEY: begin
        if (sts_i.out_free) begin
          cmd_o.wr_en     = 1'b1;
          cmd_o.wr_sel    = sukl_pkg::WA_POS;
          cmd_o.cnt_inc   = 1'b1;
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = 1'b1;
          state_d         = sukl_pkg::S_IDLE;
        end
      end

      sukl_pkg::S_SHD: begin
        if (sts_i.ra_last) begin
          if (sts_i.out_free) begin
            cmd_o.wr_en     = 1'b1;
            cmd_o.wr_sel    = sukl_pkg::WA_DOWN;
            cmd_o.cnt_dec   = 1'b1;
            cmd_o.emit      = 1'b1;
            cmd_o.emit_last = 1'b1;
            state_d         = sukl_pkg::S_IDLE;
          end
        end else begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = sukl_pkg::WA_DOWN;
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = sukl_pkg::RA_NEXT;
        end
      end

      sukl_pkg::S_LIST: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_rd   = 1'b1;
          cmd_o.emit_last = sts_i.ra_last;
          if (sts_i.ra_last) begin
            state_d = sukl_pkg::S_IDLE;
          end else begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = sukl_pkg::RA_NEXT;
          end
        end
      end

      default: state_d = sukl_pkg::S_IDLE;
    endcase
  end

endmodule

@@ hdl/sukl_dp.sv @@
// ----------------------------------------------------------------------------
// sukl_dp
// Datapath: item registers, key count, scan position, key RAM with its
// address selection, signed compare, and the result register.
// ----------------------------------------------------------------------------
module sukl_dp #(
  parameter int CAPACITY = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [1:0]     opcode_i,
  input  logic [31:0]    key_i,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output logic [2:0]     status_o,
  output logic [31:0]    key_out_o,
  output logic           last_o,
  input  sukl_pkg::cmd_t cmd_i,
  output sukl_pkg::sts_t sts_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    pos_q, pos_d;
  logic [AW-1:0]    ra_q, ra_d;
  logic             found_q, found_d;
  logic [31:0]      key_q;
  sukl_pkg::op_e    op_q;
  logic             out_valid_q;
  logic [2:0]       status_q;
  logic [31:0]      key_out_q;
  logic             last_q;

  logic [AW-1:0]    raddr, waddr;
  logic [31:0]      wdata, rd_data;
  logic [CW-1:0]    ra_ext;
  logic             out_free;

  assign ra_ext   = CW'(ra_q);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    unique case (cmd_i.rd_sel)
      sukl_pkg::RA_ZERO:  raddr = '0;
      sukl_pkg::RA_NEXT:  raddr = AW'(ra_q + 1'b1);
      sukl_pkg::RA_PREV:  raddr = AW'(ra_q - 1'b1);
      sukl_pkg::RA_CNTM1: raddr = AW'(cnt_q - 1'b1);
      sukl_pkg::RA_POSP1: raddr = AW'(pos_q + 1'b1);
      default:            raddr = '0;
    endcase
  end

  always_comb begin
    wdata = rd_data;
    unique case (cmd_i.wr_sel)
      sukl_pkg::WA_UP:   waddr = AW'(ra_q + 1'b1);
      sukl_pkg::WA_DOWN: waddr = AW'(ra_q - 1'b1);
      sukl_pkg::WA_POS: begin
        waddr = AW'(pos_q);
        wdata = key_q;
      end
      default:           waddr = '0;
    endcase
  end

  sukl_ram #(
    .WIDTH (32),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rd_data)
  );

  always_comb begin
    cnt_d   = cnt_q;
    pos_d   = pos_q;
    found_d = found_q;
    ra_d    = cmd_i.rd_en ? raddr : ra_q;
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + 1'b1;
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - 1'b1;
    end
    if (cmd_i.scan_hit) begin
      pos_d   = ra_ext;
      found_d = (rd_data == key_q);
    end else if (cmd_i.scan_end) begin
      pos_d   = cnt_q;
      found_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    found_q <= found_d;
    ra_q    <= ra_d;
    if (cmd_i.load_in) begin
      key_q <= key_i;
      op_q  <= sukl_pkg::op_e'(opcode_i);
    end
    if (cmd_i.emit) begin
      status_q  <= cmd_i.emit_status;
      last_q    <= cmd_i.emit_last;
      key_out_q <= (cmd_i.emit_status != sukl_pkg::STAT_OK) ? 32'd0 :
                   (cmd_i.emit_rd ? rd_data : key_q);
    end
  end

  always_comb begin
    sts_o.op         = op_q;
    sts_o.cnt_zero   = (cnt_q == '0);
    sts_o.cnt_full   = (cnt_q == CW'(CAPACITY));
    sts_o.ge         = ($signed(rd_data) >= $signed(key_q));
    sts_o.ra_last    = (CW'(ra_ext + 1'b1) == cnt_q);
    sts_o.ra_at_pos  = (ra_ext == pos_q);
    sts_o.pos_last   = (CW'(pos_q + 1'b1) == cnt_q);
    sts_o.pos_at_cnt = (pos_q == cnt_q);
    sts_o.found      = found_q;
    sts_o.out_free   = out_free;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign key_out_o   = key_out_q;
  assign last_o      = last_q;

endmodule

@@ hdl/sorted_unique_key_list.sv @@
// ----------------------------------------------------------------------------
// sorted_unique_key_list
// Bounded ascending set of unique signed 32-bit keys with insert, delete,
// search and list, kept in a single RAM and walked one entry per cycle unless the output stalls.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+----------------------------
//  in      | in_valid_i / in_ready_o | opcode_i, key_i
//  out     | out_valid_o / out_ready_i | status_o, key_out_o, last_o
//
//  One item at a time; the next is taken once the previous one's last result
//  is issued. Insert, delete and search scan up to the first key not below the
//  item's key; insert shifts the keys from there up, delete shifts those after
//  it down, and list streams every key. Other items on an empty store give EMPTY.
//  Reset clears the count and the output valid flag; the RAM is not cleared.
//  A stalled output holds the sequencer at its next result.
// ----------------------------------------------------------------------------
module sorted_unique_key_list #(
  parameter int CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] key_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [31:0] key_out_o,
  output logic        last_o
);

  sukl_pkg::cmd_t cmd;
  sukl_pkg::sts_t sts;

  sukl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sukl_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .opcode_i    (opcode_i),
    .key_i       (key_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .status_o    (status_o),
    .key_out_o   (key_out_o),
    .last_o      (last_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts.out_free)
    else $error("result register overwritten");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.cnt_inc |-> !sts.cnt_full)
    else $error("insert into full store");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.cnt_dec |-> !sts.cnt_zero)
    else $error("delete from empty store");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second item taken while busy");

endmodule
